/* hdl/max_distance_seat_allocator_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the seat allocator
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MAX_DISTANCE_SEAT_ALLOCATOR_MACROS_SVH
`define MAX_DISTANCE_SEAT_ALLOCATOR_MACROS_SVH

// check a condition at every edge
`define MSA_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// check a consequence in the same cycle
`define MSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check a consequence in the next cycle
`define MSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/msa_pkg.sv */
// ----------------------------------------------------------------------------
// msa_pkg
// Shared types and constants of the max-distance seat allocator.
// ----------------------------------------------------------------------------
package msa_pkg;

  localparam int MAX_SEATS_DEF = 64;
  localparam int SEAT_ID_W     = 6;
  localparam int CFG_W         = 7;

  localparam logic [CFG_W-1:0] SEAT_COUNT_RST = 7'd64;

  localparam logic KIND_TAKE    = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [SEAT_ID_W-1:0] release_seat;
  } msa_req_t;

  typedef struct packed {
    logic [SEAT_ID_W-1:0] assigned_seat;
    logic                 row_full;
  } msa_resp_t;

  typedef struct packed {
    logic start;
    logic step;
    logic occ;
  } msa_scan_ctl_t;

endpackage

/* hdl/max_distance_seat_allocator.sv */
// ----------------------------------------------------------------------------
// max_distance_seat_allocator
// Row occupancy map with take requests that pick the seat farthest from
// any occupied neighbor, and release requests that free a seat.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready with in_req; take results leave on
// out_valid/out_ready with out_resp. Releases give no result. cfg_wr_en with
// cfg_wr_data sets the number of seats in use; the registered count is used
// directly, so a write also applies to a scan in progress.
// After reset the map is swept clear, one seat per cycle, over all MAX_SEATS
// seats; in_ready stays low meanwhile.
// A release completes in the cycle it is accepted; in_ready stays high.
// A take scans the n seats in use through one registered read port and one
// shared gap compare unit, one seat per cycle; a drain state then lets the
// last read reach the gap unit, and the done state registers the result and
// opens in_ready for the next request.
// A request may be accepted while a result still waits in the output
// register; a take that finishes while the receiver stalls holds its result
// and in_ready low until the output register is free.
// ----------------------------------------------------------------------------
`include "max_distance_seat_allocator_macros.svh"

module max_distance_seat_allocator #(
  parameter int MAX_SEATS = msa_pkg::MAX_SEATS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  msa_pkg::msa_req_t          in_req,
  output logic                       out_valid,
  input  logic                       out_ready,
  output msa_pkg::msa_resp_t         out_resp,
  input  logic                       cfg_wr_en,
  input  logic [msa_pkg::CFG_W-1:0]  cfg_wr_data
);
  import msa_pkg::*;

  localparam int SEAT_W = $clog2(MAX_SEATS);
  localparam int CNT_W  = SEAT_W + 1;
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]       state_r;
  logic [2:0]       state_nxt;
  logic [CFG_W-1:0] seat_count_r;
  logic [SEAT_W-1:0] clr_cnt_r;
  logic [SEAT_W-1:0] cnt_r;
  logic              step_r;
  logic [SEAT_W-1:0] idx_r;
  logic              out_valid_r;
  msa_resp_t         out_resp_r;

  logic [CNT_W-1:0]  n_act;
  logic [SEAT_W-1:0] n_m1;
  logic              in_fire;
  logic              done_fire;
  logic              rel_ok;

  logic              wr_en;
  logic [SEAT_W-1:0] wr_addr;
  logic              wr_data;
  logic              rd_en;
  logic              rd_data;

  msa_scan_ctl_t     scan_ctl;
  logic [SEAT_W-1:0] pick_seat;
  logic              pick_full;

  // clamp the seat count to 1..MAX_SEATS
  always_comb begin
    if (seat_count_r == '0) begin
      n_act = CNT_W'(1);
    end else if (CMP_W'(seat_count_r) > CMP_W'(MAX_SEATS)) begin
      n_act = CNT_W'(MAX_SEATS);
    end else begin
      n_act = CNT_W'(seat_count_r);
    end
  end

  assign n_m1      = SEAT_W'(n_act - CNT_W'(1));
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign done_fire = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign rel_ok    = CMP_W'(in_req.release_seat) < CMP_W'(n_act);
  assign rd_en     = (state_r == ST_SCAN);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = 1'b0;
    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
    end else if (in_fire && in_req.kind == KIND_RELEASE && rel_ok) begin
      wr_en   = 1'b1;
      wr_addr = SEAT_W'(in_req.release_seat);
    end else if (done_fire && !pick_full) begin
      wr_en   = 1'b1;
      wr_addr = pick_seat;
      wr_data = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == SEAT_W'(MAX_SEATS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire && in_req.kind == KIND_TAKE) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_r == n_m1) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE: begin
        if (done_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      seat_count_r <= SEAT_COUNT_RST;
      clr_cnt_r    <= '0;
      cnt_r        <= '0;
      step_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= rd_en;
      if (cfg_wr_en) begin
        seat_count_r <= cfg_wr_data;
      end
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + SEAT_W'(1);
      end
      if (in_fire) begin
        cnt_r <= '0;
      end else if (rd_en) begin
        cnt_r <= cnt_r + SEAT_W'(1);
      end
      if (done_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= cnt_r;
    if (done_fire) begin
      out_resp_r.assigned_seat <= SEAT_ID_W'(pick_seat);
      out_resp_r.row_full      <= pick_full;
    end
  end

  assign scan_ctl.start = in_fire;
  assign scan_ctl.step  = step_r;
  assign scan_ctl.occ   = rd_data;

  assign out_valid = out_valid_r;
  assign out_resp  = out_resp_r;

  msa_seat_map #(
    .MAX_SEATS (MAX_SEATS)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (cnt_r),
    .rd_data (rd_data)
  );

  msa_gap_scan #(
    .MAX_SEATS (MAX_SEATS)
  ) u_scan (
    .clk       (clk),
    .ctl       (scan_ctl),
    .idx       (idx_r),
    .last_seat (n_m1),
    .seat      (pick_seat),
    .full      (pick_full)
  );

  `MSA_ASSERT_IMP(a_full_seat_zero, out_valid_r && out_resp_r.row_full,
                  out_resp_r.assigned_seat == '0, "full result with nonzero seat")
  `MSA_ASSERT_IMP(a_seat_in_range, out_valid_r && !out_resp_r.row_full,
                  CMP_W'(out_resp_r.assigned_seat) < CMP_W'(n_act), "seat beyond count")
  `MSA_ASSERT_NXT(a_done_loads_out, done_fire, out_valid_r, "result not registered")
  `MSA_ASSERT_IMP(a_no_read_in_clear, state_r == ST_CLEAR, !rd_en, "read during clear")
  `MSA_ASSERT_IMP(a_scan_bound, state_r == ST_SCAN,
                  CNT_W'(cnt_r) < n_act, "scan index past count")

endmodule

/* hdl/msa_seat_map.sv */
// ----------------------------------------------------------------------------
// msa_seat_map
// Occupancy memory: one bit per seat, one write and one registered read port.
// ----------------------------------------------------------------------------
module msa_seat_map #(
  parameter int MAX_SEATS = msa_pkg::MAX_SEATS_DEF
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_SEATS)-1:0] wr_addr,
  input  logic                         wr_data,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_SEATS)-1:0] rd_addr,
  output logic                         rd_data
);

  logic mem [MAX_SEATS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/msa_gap_scan.sv */
// ----------------------------------------------------------------------------
// msa_gap_scan
// Shared gap unit: takes one seat per step, tracks the widest gap and
// resolves the head, midpoint and tail candidates into the chosen seat.
// ----------------------------------------------------------------------------
module msa_gap_scan #(
  parameter int MAX_SEATS = msa_pkg::MAX_SEATS_DEF,
  localparam int SEAT_W   = $clog2(MAX_SEATS)
) (
  input  logic                  clk,
  input  msa_pkg::msa_scan_ctl_t ctl,
  input  logic [SEAT_W-1:0]     idx,
  input  logic [SEAT_W-1:0]     last_seat,
  output logic [SEAT_W-1:0]     seat,
  output logic                  full
);
  import msa_pkg::*;

  logic              any_r;
  logic              best_ok_r;
  logic [SEAT_W-1:0] last_r;
  logic [SEAT_W-1:0] best_r;
  logic [SEAT_W-1:0] best_dist_r;
  logic [SEAT_W-1:0] half;
  logic [SEAT_W-1:0] tail_d;

  assign half   = (idx - last_r) >> 1;
  assign tail_d = last_seat - last_r;

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      any_r       <= 1'b0;
      best_ok_r   <= 1'b0;
      last_r      <= '0;
      best_r      <= '0;
      best_dist_r <= '0;
    end else if (ctl.step && ctl.occ) begin
      if (!any_r) begin
        if (idx > best_dist_r) begin
          best_dist_r <= idx;
          best_r      <= '0;
          best_ok_r   <= 1'b1;
        end
        any_r <= 1'b1;
      end else if (half > best_dist_r) begin
        best_dist_r <= half;
        best_r      <= last_r + half;
        best_ok_r   <= 1'b1;
      end
      last_r <= idx;
    end
  end

  always_comb begin
    seat = '0;
    full = 1'b0;
    if (!any_r) begin
      seat = '0;
    end else if (tail_d > best_dist_r) begin
      seat = last_seat;
    end else if (best_ok_r) begin
      seat = best_r;
    end else begin
      full = 1'b1;
    end
  end

endmodule
